// ----- src/census_pkg.sv -----
package census_pkg;

	localparam int PIXEL_W      = 8;
	localparam int CENSUS_W     = 48;
	localparam int COORD_W      = 10;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 11;

	localparam int WINDOW_DEF    = 7;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 1024;
	localparam int HEIGHT_W      = 11;

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

	// depth of the result queue in front of the output
	localparam int RES_DEPTH = 4;

	typedef struct packed {
		logic [CENSUS_W-1:0] census_word;
		logic [COORD_W-1:0]  center_row;
		logic [COORD_W-1:0]  center_col;
		logic                frame_end;
	} census_result_t;

endpackage

// ----- src/census_ifs.sv -----
interface census_pixel_if;
	import census_pkg::*;
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface census_result_if;
	import census_pkg::*;
	logic                valid;
	logic                ready;
	logic [CENSUS_W-1:0] census_word;
	logic [COORD_W-1:0]  center_row;
	logic [COORD_W-1:0]  center_col;
	logic                frame_end;

	modport source (output valid, output census_word, output center_row,
		output center_col, output frame_end, input ready);
	modport sink (input valid, input census_word, input center_row,
		input center_col, input frame_end, output ready);
endinterface

interface census_config_if;
	import census_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/census_transform_7x7.sv -----
// pipeline: an accepted pixel is registered in stage 1, its column enters the window
//   and the census word from stage 2 is written into the result queue, which drives the output
// throughput: one pixel per cycle while the result queue has room, set by the line store,
//   which reads one column at the request and writes it back shifted in the next cycle
// reset (arst_n low): position back to row 0 column 0, window and result queue
//   cleared, size 640 x 480; the line store keeps its contents and needs no clearing
module census_transform_7x7 #(
	parameter int WINDOW    = census_pkg::WINDOW_DEF,
	parameter int MAX_WIDTH = census_pkg::MAX_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	census_pixel_if.sink     pix,
	census_result_if.source  res,
	census_config_if.sink    cfg
);
	import census_pkg::*;

	localparam int HALF      = WINDOW / 2;
	localparam int LINES     = WINDOW - 1;
	localparam int NBITS     = WINDOW * WINDOW - 1;
	localparam int CENTRE    = HALF * WINDOW + HALF;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WID_W     = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W     = (WID_W > CFG_DATA_W) ? WID_W : CFG_DATA_W;
	localparam int CCOL_W    = (COL_W > COORD_W) ? COL_W : COORD_W;
	localparam int LINE_W    = LINES * PIXEL_W;
	localparam int RST_WID   = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
	localparam int PTR_W     = $clog2(RES_DEPTH);
	localparam int CNT_W     = $clog2(RES_DEPTH + 1);

	// ---------------------------------------------------------------------
	// frame size and position
	// ---------------------------------------------------------------------
	logic [WID_W-1:0]    width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [COL_W-1:0]    col_q;
	logic [COORD_W-1:0]  row_q;

	logic [CMP_W-1:0]    cfg_data_ext;
	logic [WID_W-1:0]    width_clamped;
	logic [HEIGHT_W-1:0] height_clamped;

	logic in_acc;
	logic last_col;
	logic last_row;
	logic emit_c;
	logic [CCOL_W-1:0]   ccol_ext;

	assign cfg.ready    = 1'b1;
	assign cfg_data_ext = CMP_W'(cfg.data);

	// saturate the written size into the supported range
	always_comb begin
		if (cfg_data_ext < CMP_W'(WINDOW))
			width_clamped = WID_W'(WINDOW);
		else if (cfg_data_ext > CMP_W'(MAX_WIDTH))
			width_clamped = WID_W'(MAX_WIDTH);
		else
			width_clamped = WID_W'(cfg_data_ext);

		if (cfg.data < CFG_DATA_W'(WINDOW))
			height_clamped = HEIGHT_W'(WINDOW);
		else if (cfg.data > CFG_DATA_W'(MAX_HEIGHT))
			height_clamped = HEIGHT_W'(MAX_HEIGHT);
		else
			height_clamped = HEIGHT_W'(cfg.data);
	end

	assign in_acc   = pix.valid && pix.ready;
	assign last_col = (WID_W'(col_q) == width_q - WID_W'(1));
	assign last_row = (HEIGHT_W'(row_q) == height_q - HEIGHT_W'(1));
	// a full neighbourhood sits in the window once the pixel is past the top
	// and left borders
	assign emit_c   = (row_q >= COORD_W'(WINDOW - 1)) && (col_q >= COL_W'(WINDOW - 1));
	assign ccol_ext = CCOL_W'(col_q) - CCOL_W'(HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WID_W'(RST_WID);
			height_q <= HEIGHT_W'(RESET_HEIGHT);
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (cfg.valid && cfg.ready &&
				(cfg.index == REG_IMAGE_WIDTH || cfg.index == REG_IMAGE_HEIGHT)) begin
				if (cfg.index == REG_IMAGE_WIDTH)
					width_q <= width_clamped;
				else
					height_q <= height_clamped;
				// a size change restarts the frame
				col_q <= '0;
				row_q <= '0;
			end else if (in_acc) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + COORD_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// stage 1: line store read returns, column written back shifted by one line
	// ---------------------------------------------------------------------
	logic               v_s1;
	logic               emit_s1;
	logic [PIXEL_W-1:0] pixel_s1;
	logic [COL_W-1:0]   col_s1;
	logic [COORD_W-1:0] crow_s1;
	logic [COORD_W-1:0] ccol_s1;
	logic               fend_s1;

	logic [LINE_W-1:0]  line_mem [MAX_WIDTH];
	logic [LINE_W-1:0]  line_rd_s1;
	logic [LINE_W-1:0]  line_wr;
	logic [PIXEL_W-1:0] column [WINDOW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= in_acc;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pixel_s1 <= pix.pixel;
			col_s1   <= col_q;
			emit_s1  <= emit_c;
			crow_s1  <= row_q - COORD_W'(HALF);
			ccol_s1  <= ccol_ext[COORD_W-1:0];
			fend_s1  <= last_row && last_col;
		end
	end

	// one column of the line store per pixel; read and write never meet on
	// the same column since a row is at least a window wide
	always_ff @(posedge clk) begin
		if (in_acc)
			line_rd_s1 <= line_mem[col_q];
		if (v_s1)
			line_mem[col_s1] <= line_wr;
	end

	always_comb begin
		for (int k = 0; k < LINES; k++)
			column[k] = line_rd_s1[k*PIXEL_W +: PIXEL_W];
		column[WINDOW-1] = pixel_s1;
		for (int k = 0; k < LINES; k++)
			line_wr[k*PIXEL_W +: PIXEL_W] = column[k+1];
	end

	// window moves one column left, new column enters on the right
	logic [PIXEL_W-1:0] win_q [WINDOW][WINDOW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++)
				for (int j = 0; j < WINDOW; j++)
					win_q[i][j] <= '0;
		end else if (v_s1) begin
			for (int i = 0; i < WINDOW; i++) begin
				for (int j = 0; j < WINDOW - 1; j++)
					win_q[i][j] <= win_q[i][j+1];
				win_q[i][WINDOW-1] <= column[i];
			end
		end
	end

	// ---------------------------------------------------------------------
	// stage 2: compare the settled window against its centre
	// ---------------------------------------------------------------------
	logic               v_s2;
	logic               emit_s2;
	logic [COORD_W-1:0] crow_s2;
	logic [COORD_W-1:0] ccol_s2;
	logic               fend_s2;
	logic [CENSUS_W-1:0] census_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			emit_s2 <= 1'b0;
		end else begin
			v_s2    <= v_s1;
			emit_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			crow_s2 <= crow_s1;
			ccol_s2 <= ccol_s1;
			fend_s2 <= fend_s1;
		end
	end

	// neighbours in raster order, first one in the top bit, centre skipped
	always_comb begin
		census_c = '0;
		for (int i = 0; i < WINDOW; i++) begin
			for (int j = 0; j < WINDOW; j++) begin
				if (i * WINDOW + j < CENTRE)
					census_c[NBITS-1-(i*WINDOW+j)] = (win_q[i][j] > win_q[HALF][HALF]);
				else if (i * WINDOW + j > CENTRE)
					census_c[NBITS-(i*WINDOW+j)] = (win_q[i][j] > win_q[HALF][HALF]);
			end
		end
	end

	// ---------------------------------------------------------------------
	// result queue: parts the pipeline from the output handshake
	// ---------------------------------------------------------------------
	census_result_t   rq_mem [RES_DEPTH];
	census_result_t   rq_head;
	logic [PTR_W-1:0] rq_wr_q;
	logic [PTR_W-1:0] rq_rd_q;
	logic [CNT_W-1:0] rq_cnt_q;
	logic [CNT_W:0]   in_flight;
	logic             rq_push;
	logic             rq_pop;

	assign rq_push = emit_s2;
	assign rq_pop  = res.valid && res.ready;

	// every pixel in the pipeline holds a place, so a result always finds room
	assign in_flight = (CNT_W+1)'(rq_cnt_q) + (CNT_W+1)'(v_s1) + (CNT_W+1)'(v_s2);
	assign pix.ready = (in_flight < (CNT_W+1)'(RES_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (rq_push)
				rq_wr_q <= rq_wr_q + PTR_W'(1);
			if (rq_pop)
				rq_rd_q <= rq_rd_q + PTR_W'(1);
			if (rq_push && !rq_pop)
				rq_cnt_q <= rq_cnt_q + CNT_W'(1);
			else if (rq_pop && !rq_push)
				rq_cnt_q <= rq_cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (rq_push) begin
			rq_mem[rq_wr_q].census_word <= census_c;
			rq_mem[rq_wr_q].center_row  <= crow_s2;
			rq_mem[rq_wr_q].center_col  <= ccol_s2;
			rq_mem[rq_wr_q].frame_end   <= fend_s2;
		end
	end

	assign rq_head         = rq_mem[rq_rd_q];
	assign res.valid       = (rq_cnt_q != '0);
	assign res.census_word = rq_head.census_word;
	assign res.center_row  = rq_head.center_row;
	assign res.center_col  = rq_head.center_col;
	assign res.frame_end   = rq_head.frame_end;

	// ---------------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------------
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cnt_q <= CNT_W'(RES_DEPTH))
		else $error("result queue over its depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rq_push |-> (rq_cnt_q < CNT_W'(RES_DEPTH)) || rq_pop)
		else $error("result pushed into a full queue");

	a_stage_follow: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> v_s1 ##1 v_s2)
		else $error("accepted pixel lost in the pipeline");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_col) |=> (col_q == '0))
		else $error("column did not wrap at row end");

	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		pix.ready |-> (rq_cnt_q < CNT_W'(RES_DEPTH)))
		else $error("input ready with the result queue full");

endmodule

// ----- verif/tb_census_transform_7x7.sv -----
`timescale 1ns / 100ps

module tb_census_transform_7x7;
	import census_pkg::*;

	localparam int WIN          = WINDOW_DEF;
	localparam int HALF         = WIN / 2;
	localparam int CENTRE_POS   = HALF * WIN + HALF;
	localparam int NO_HOT       = -1;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 40;
	localparam int LIMIT_NS     = 20_000_000;

	// indexes the block has no register behind
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = CFG_INDEX_W'(3);

	typedef enum int {TEX_UNIFORM, TEX_NEAR, TEX_BINARY} texture_e;

	logic clk;
	logic arst_n;

	census_pixel_if  pix_if ();
	census_result_if res_if ();
	census_config_if cfg_if ();

	census_transform_7x7 i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	// shadow of the block: size registers, raster position, line stores, window
	logic [CFG_DATA_W-1:0] width_reg;
	logic [CFG_DATA_W-1:0] height_reg;
	int                    next_row;
	int                    next_col;
	bit [PIXEL_W-1:0]      line_mem [WIN-1][MAX_WIDTH_DEF];
	bit [PIXEL_W-1:0]      win_pix [WIN][WIN];

	// census words still owed by the block, oldest first
	census_result_t census_expected [$];
	// pixels waiting for the driver
	logic [PIXEL_W-1:0] pending_pixels [$];

	bit pix_loaded;
	int pix_gap;
	bit pix_calm;
	int res_stall;
	bit res_calm;

	int pixels_in;
	int words_seen;
	int frame_ends_seen;
	int reg_writes;
	int errors;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// size in use: register value saturated into the range the block supports
	function automatic int clamp_dim(input logic [CFG_DATA_W-1:0] v, input int hi);
		if (int'(v) < WIN)
			return WIN;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	// one pixel request through the shadow; queues the census word it causes
	function automatic void census_step(input logic [PIXEL_W-1:0] px);
		int w;
		int h;
		int r;
		int c;
		int i;
		int j;
		int k;
		bit [PIXEL_W-1:0] column [WIN];
		bit [PIXEL_W-1:0] centre;
		census_result_t predicted;
		w = clamp_dim(width_reg, MAX_WIDTH_DEF);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		r = (next_row >= h) ? 0 : next_row;
		c = (next_col >= w) ? 0 : next_col;
		// read one column of the line stores, write it back moved up by one row
		for (k = 0; k < WIN - 1; k++)
			column[k] = line_mem[k][c];
		column[WIN-1] = px;
		for (k = 0; k < WIN - 1; k++)
			line_mem[k][c] = column[k+1];
		// window slides left, new column enters on the right
		for (i = 0; i < WIN; i++) begin
			for (j = 0; j < WIN - 1; j++)
				win_pix[i][j] = win_pix[i][j+1];
			win_pix[i][WIN-1] = column[i];
		end
		if (r >= WIN - 1 && c >= WIN - 1) begin
			centre = win_pix[HALF][HALF];
			predicted.census_word = '0;
			// raster order, centre skipped, first neighbour ends in the msb
			for (i = 0; i < WIN; i++) begin
				for (j = 0; j < WIN; j++) begin
					if (!(i == HALF && j == HALF))
						predicted.census_word = {predicted.census_word[CENSUS_W-2:0],
							win_pix[i][j] > centre};
				end
			end
			predicted.center_row = COORD_W'(r - HALF);
			predicted.center_col = COORD_W'(c - HALF);
			predicted.frame_end  = (r == h - 1 && c == w - 1);
			census_expected.push_back(predicted);
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		next_col = c;
		next_row = r;
	endfunction

	// idle length: none in calm stretches, else mostly short and now and then long
	function automatic int pick_gap(input bit calm);
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 12);
	endfunction

	function automatic texture_e pick_texture();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return TEX_UNIFORM;
		if (roll < 85)
			return TEX_NEAR;
		return TEX_BINARY;
	endfunction

	// near texture keeps many neighbours equal to or just off the centre
	function automatic logic [PIXEL_W-1:0] texture_pixel(input texture_e tex, input int base);
		int v;
		case (tex)
			TEX_NEAR: begin
				v = base + int'($urandom_range(0, 6)) - 3;
				if (v < 0)
					v = 0;
				if (v > 255)
					v = 255;
				return PIXEL_W'(v);
			end
			TEX_BINARY: return $urandom_range(0, 1) ? 8'hff : 8'h00;
			default: return PIXEL_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_dim();
		if ($urandom_range(0, 99) < 75)
			return CFG_DATA_W'($urandom_range(WIN, 12));
		return CFG_DATA_W'($urandom_range(0, WIN - 1));
	endfunction

	function automatic void flag_mismatch(input string field, input logic [CENSUS_W-1:0] want,
		input logic [CENSUS_W-1:0] got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
	endfunction

	// random pixels, texture and brightness changing after runs of 1 to 64 pixels
	task automatic queue_random(input int n);
		texture_e tex;
		int base;
		int run;
		int k;
		tex  = TEX_UNIFORM;
		base = 0;
		run  = 0;
		for (k = 0; k < n; k++) begin
			if (run == 0) begin
				tex  = pick_texture();
				base = $urandom_range(0, 255);
				run  = $urandom_range(1, 64);
			end
			run--;
			pending_pixels.push_back(texture_pixel(tex, base));
		end
	endtask

	// one 7x7 frame: flat fill, chosen centre, optionally one odd neighbour
	task automatic queue_window(input int centre, input int fill, input int hot_pos,
		input int hot_val);
		int p;
		for (p = 0; p < WIN * WIN; p++) begin
			if (p == CENTRE_POS)
				pending_pixels.push_back(PIXEL_W'(centre));
			else if (p == hot_pos)
				pending_pixels.push_back(PIXEL_W'(hot_val));
			else
				pending_pixels.push_back(PIXEL_W'(fill));
		end
	endtask

	// register write request, shadow updated on acceptance
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		cfg_if.valid <= 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		reg_writes++;
		// a size write restarts the frame, the spare indexes change nothing
		if (idx == REG_IMAGE_WIDTH) begin
			width_reg = val;
			next_row  = 0;
			next_col  = 0;
		end else if (idx == REG_IMAGE_HEIGHT) begin
			height_reg = val;
			next_row   = 0;
			next_col   = 0;
		end
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// block idle: all pixels taken, all words back, pipeline drained
	task automatic settle();
		while (pending_pixels.size() != 0 || pix_loaded || census_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// pixel driver: inputs move on the falling edge only
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0)
			pix_calm = !pix_calm;
		if (!arst_n) begin
			pix_if.valid <= 1'b0;
		end else if (!pix_loaded) begin
			if (pix_gap > 0) begin
				pix_gap--;
				pix_if.valid <= 1'b0;
			end else if (pending_pixels.size() > 0) begin
				pix_if.pixel <= pending_pixels.pop_front();
				pix_if.valid <= 1'b1;
				pix_loaded = 1'b1;
			end else begin
				pix_if.valid <= 1'b0;
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0)
			res_calm = !res_calm;
		if (res_stall > 0) begin
			res_stall--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= 1'b1;
			res_stall = pick_gap(res_calm);
		end
	end

	// monitor: results checked first, then the pixel request of this edge predicted
	always @(posedge clk) begin
		census_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			words_seen++;
			if (res_if.frame_end)
				frame_ends_seen++;
			if (census_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected census word, expected none, got %012h row %0d col %0d",
					$time, res_if.census_word, res_if.center_row, res_if.center_col);
			end else begin
				want = census_expected.pop_front();
				if (res_if.census_word !== want.census_word)
					flag_mismatch("census_word", want.census_word, res_if.census_word);
				if (res_if.center_row !== want.center_row)
					flag_mismatch("center_row", CENSUS_W'(want.center_row),
						CENSUS_W'(res_if.center_row));
				if (res_if.center_col !== want.center_col)
					flag_mismatch("center_col", CENSUS_W'(want.center_col),
						CENSUS_W'(res_if.center_col));
				if (res_if.frame_end !== want.frame_end)
					flag_mismatch("frame_end", CENSUS_W'(want.frame_end),
						CENSUS_W'(res_if.frame_end));
			end
		end
		if (arst_n && pix_if.valid && pix_if.ready) begin
			census_step(pix_if.pixel);
			pixels_in++;
			pix_loaded = 1'b0;
			pix_gap    = pick_gap(pix_calm);
		end
	end

	initial begin
		int mix [5];
		int p;
		int s;
		int w;
		int h;
		mix = '{127, 128, 129, 0, 255};
		// every input known from time zero
		pix_if.valid = 1'b0;
		pix_if.pixel = '0;
		res_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_IMAGE_WIDTH;
		cfg_if.data  = '0;
		pix_loaded   = 1'b0;
		pix_gap      = 0;
		res_stall    = 0;
		width_reg    = CFG_DATA_W'(RESET_WIDTH);
		height_reg   = CFG_DATA_W'(RESET_HEIGHT);
		next_row     = 0;
		next_col     = 0;
		arst_n       = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset size: part of the first row, no word may appear yet
		queue_random(30);
		settle();

		// smallest frame: one word per frame, the whole window is the frame
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(WIN));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(WIN));
		queue_window(0, 255, NO_HOT, 0);               // every neighbour brighter
		queue_window(255, 0, NO_HOT, 0);               // brightest centre, word all zero
		queue_window(100, 100, 0, 101);                // only first neighbour brighter
		queue_window(100, 100, WIN * WIN - 1, 101);    // only last neighbour brighter
		queue_window(200, 200, CENTRE_POS - 1, 201);   // neighbour left of the centre
		queue_window(200, 200, CENTRE_POS + 1, 201);   // neighbour right of the centre
		// equal, one below and one above the centre side by side
		for (p = 0; p < WIN * WIN; p++) begin
			if (p == CENTRE_POS)
				pending_pixels.push_back(PIXEL_W'(128));
			else
				pending_pixels.push_back(PIXEL_W'(mix[p % 5]));
		end
		// spare indexes mid-frame must not restart the frame
		queue_random(20);
		settle();
		write_reg(REG_SPARE_2, CFG_DATA_W'($urandom_range(0, 2047)));
		write_reg(REG_SPARE_3, CFG_DATA_W'($urandom_range(0, 2047)));
		queue_random(WIN * WIN - 20);
		settle();

		// width below the window saturates up, tallest frame: top rows only
		write_reg(REG_IMAGE_WIDTH, '0);
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(MAX_HEIGHT));
		queue_random(WIN * 16);
		settle();

		// widest frame from an over-range width, height zero saturates up;
		// a short part of the first row gives no word
		write_reg(REG_IMAGE_HEIGHT, '0);
		write_reg(REG_IMAGE_WIDTH, '1);
		queue_random(60);
		settle();

		// random small sizes, one or two whole frames, sometimes a partial one after
		for (s = 0; s < 2; s++) begin
			case ((s == 0) ? 0 : $urandom_range(0, 2))
				0: begin
					write_reg(REG_IMAGE_WIDTH, pick_dim());
					write_reg(REG_IMAGE_HEIGHT, pick_dim());
				end
				1: write_reg(REG_IMAGE_WIDTH, pick_dim());
				default: write_reg(REG_IMAGE_HEIGHT, pick_dim());
			endcase
			w = clamp_dim(width_reg, MAX_WIDTH_DEF);
			h = clamp_dim(height_reg, MAX_HEIGHT);
			queue_random(w * h * $urandom_range(1, 2));
			if ($urandom_range(0, 1))
				queue_random($urandom_range(1, w * h - 1));
			settle();
		end

		$display("covered %0d pixels, %0d census words and %0d frame ends",
			pixels_in, words_seen, frame_ends_seen);
		$display("over %0d register writes, sizes from below 7 up to past 1024",
			reg_writes);
		if (errors == 0 && census_expected.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#LIMIT_NS;
		$display("%0t: timed out with %0d census words outstanding", $time,
			census_expected.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
